### design/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants of the 4x4 matrix multiplier
// Sizes, the fixed-point format, and the structs passed between the
// load front end, the bank queue and the compute back end.
// ----------------------------------------------------------------------------
package mm4_pkg;

   localparam int MATRIX_DIM  = 4;
   localparam int FRAC_BITS   = 16;
   localparam int ELEMS       = MATRIX_DIM * MATRIX_DIM;
   localparam int IDX_W       = $clog2(ELEMS);
   localparam int DIM_W       = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
   localparam int NUM_BANKS   = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int PROD_W      = 2 * VALUE_W;
   localparam int ACC_W       = PROD_W + $clog2(MATRIX_DIM);

   localparam logic [VALUE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] SAT_MIN = 32'h8000_0000;

   // element write from the front end into the stores
   typedef struct packed {
      logic               en;
      logic               bank;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] left;
      logic [VALUE_W-1:0] right;
   } mm4_wr_type;

   // bank queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
      logic head_bank;
   } mm4_q_status_type;

   // tag carried alongside each product term in the back end
   typedef struct packed {
      logic             first_k;
      logic             last_k;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic             last_res;
   } mm4_tag_type;

endpackage

### design/mm4_front.sv
// ----------------------------------------------------------------------------
// mm4_front: load front end
// Accepts element pairs, steers them into the free store bank and hands
// the bank to the queue once a full pair of matrices has been loaded.
// ----------------------------------------------------------------------------
module mm4_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,
   input  mm4_pkg::mm4_q_status_type q_status,
   output mm4_pkg::mm4_wr_type       wr,
   output logic                      push,
   output logic                      push_bank
);
   import mm4_pkg::*;

   logic [IDX_W-1:0] count_ff, count_in;
   logic             bank_ff, bank_in;
   logic             accept;
   logic             at_end;

   // take a transaction whenever a bank is free
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign at_end     = (count_ff == IDX_W'(ELEMS - 1));

   // drive the store write
   always_comb begin
      wr.en    = accept;
      wr.bank  = bank_ff;
      wr.idx   = count_ff;
      wr.left  = req_tdata[31:0];
      wr.right = req_tdata[63:32];
   end

   assign push      = accept && at_end;
   assign push_bank = bank_ff;

   // advance the element counter, switch banks after the last element
   always_comb begin
      count_in = count_ff;
      bank_in  = bank_ff;
      if (accept) begin
         if (at_end) begin
            count_in = '0;
            bank_in  = !bank_ff;
         end else begin
            count_in = count_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

### design/mm4_queue.sv
// ----------------------------------------------------------------------------
// mm4_queue: bank token queue
// Short FIFO of loaded bank numbers between the front and back ends.
// ----------------------------------------------------------------------------
module mm4_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      push_bank,
   input  logic                      pop,
   output mm4_pkg::mm4_q_status_type q_status
);
   import mm4_pkg::*;

   logic              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      q_status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      q_status.empty     = (count_ff == '0);
      q_status.head_bank = slot_ff[rd_ptr_ff];
   end

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold the bank number
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_bank;
      end
   end

   // occupancy stays within depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("bank queue over depth");

   // no pop from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("bank queue popped while empty");

   // no push into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != QCNT_W'(QUEUE_DEPTH))
      else $error("bank queue pushed while full");

endmodule

### design/mm4_back.sv
// ----------------------------------------------------------------------------
// mm4_back: compute back end
// Holds the banked element stores, walks row, column and term of each
// result, multiplies, accumulates, then shifts and saturates into the
// output register. The whole pipe stalls while the output is held.
// ----------------------------------------------------------------------------
module mm4_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mm4_pkg::mm4_wr_type       wr,
   input  mm4_pkg::mm4_q_status_type q_status,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,
   output logic [3:0]                rsp_tuser,
   output logic                      rsp_tlast
);
   import mm4_pkg::*;

   // element stores, two banks each
   logic [VALUE_W-1:0] left_mem  [NUM_BANKS][ELEMS];
   logic [VALUE_W-1:0] right_mem [NUM_BANKS][ELEMS];

   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] a_idx, b_idx;
   logic             advance;
   logic             issue;
   logic             row_end, col_end, k_end;
   mm4_tag_type      issue_tag;

   logic               s1_valid_ff;
   mm4_tag_type        s1_tag_ff;
   logic [VALUE_W-1:0] s1_a_ff, s1_b_ff;

   logic               s2_valid_ff;
   mm4_tag_type        s2_tag_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;

   logic               s3_valid_ff;
   logic [DIM_W-1:0]   s3_row_ff, s3_col_ff;
   logic               s3_last_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic signed [ACC_W-1:0] shifted;
   logic [VALUE_W-1:0]      sat_value;
   logic                    in_range;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic [3:0]         rsp_user_ff;
   logic               rsp_last_ff;

   // store writes from the front end
   always_ff @(posedge clock) begin
      if (wr.en) begin
         left_mem[wr.bank][wr.idx]  <= wr.left;
         right_mem[wr.bank][wr.idx] <= wr.right;
      end
   end

   // stall everything while the output register is held
   assign advance = !rsp_valid_ff || rsp_tready;
   assign issue   = advance && !q_status.empty;

   assign row_end = (row_ff == DIM_W'(MATRIX_DIM - 1));
   assign col_end = (col_ff == DIM_W'(MATRIX_DIM - 1));
   assign k_end   = (k_ff == DIM_W'(MATRIX_DIM - 1));
   assign pop     = issue && row_end && col_end && k_end;

   assign a_idx = IDX_W'(row_ff) * IDX_W'(MATRIX_DIM) + IDX_W'(k_ff);
   assign b_idx = IDX_W'(k_ff) * IDX_W'(MATRIX_DIM) + IDX_W'(col_ff);

   always_comb begin
      issue_tag.first_k  = (k_ff == '0);
      issue_tag.last_k   = k_end;
      issue_tag.row      = row_ff;
      issue_tag.col      = col_ff;
      issue_tag.last_res = row_end && col_end;
   end

   // step term, then column, then row
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      k_in   = k_ff;
      if (issue) begin
         if (!k_end) begin
            k_in = k_ff + DIM_W'(1);
         end else begin
            k_in = '0;
            if (!col_end) begin
               col_in = col_ff + DIM_W'(1);
            end else begin
               col_in = '0;
               row_in = row_end ? '0 : row_ff + DIM_W'(1);
            end
         end
      end
   end

   // control registers of the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         k_ff   <= k_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff && s2_tag_ff.last_k;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // read both stores at the issued term
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_a_ff   <= left_mem[q_status.head_bank][a_idx];
         s1_b_ff   <= right_mem[q_status.head_bank][b_idx];
         s1_tag_ff <= issue_tag;
      end
   end

   // multiply one term
   always_ff @(posedge clock) begin
      if (advance) begin
         s2_prod_ff <= $signed(s1_a_ff) * $signed(s1_b_ff);
         s2_tag_ff  <= s1_tag_ff;
      end
   end

   // accumulate, restart on the first term
   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         if (s2_tag_ff.first_k) begin
            acc_in = ACC_W'(s2_prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(s2_prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff     <= acc_in;
         s3_row_ff  <= s2_tag_ff.row;
         s3_col_ff  <= s2_tag_ff.col;
         s3_last_ff <= s2_tag_ff.last_res;
      end
   end

   // drop fraction bits and saturate to 32 bits
   always_comb begin
      shifted  = acc_ff >>> FRAC_BITS;
      in_range = (&shifted[ACC_W-1:VALUE_W-1]) || !(|shifted[ACC_W-1:VALUE_W-1]);
      if (in_range) begin
         sat_value = shifted[VALUE_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat_value = SAT_MIN;
      end else begin
         sat_value = SAT_MAX;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= sat_value;
         rsp_user_ff <= {2'(s3_col_ff), 2'(s3_row_ff)};
         rsp_last_ff <= s3_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a held output freezes the accumulator
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(acc_ff) && $stable(s3_valid_ff))
      else $error("pipe moved while output stalled");

   // the final result of a run sits at the last row and column
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_user_ff[1:0] == 2'(MATRIX_DIM - 1)) && (rsp_user_ff[3:2] == 2'(MATRIX_DIM - 1)))
      else $error("last flag off the final element");

endmodule

### design/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply: 4x4 signed Q16.16 matrix product
// Loads two matrices element by element and streams out their product.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: each transaction carries one element of the left matrix
//   (tdata[31:0]) and one of the right matrix (tdata[63:32]), row-major.
//   After sixteen transactions the pair is complete and the product streams
//   out on the rsp channel: sixteen elements, row by row, with the row and
//   column in tuser and tlast on the final element.
//   Loading goes into one of two store banks while the other bank is being
//   computed, so the next pair loads during the current product.
//   After the last load, the first result passes the store read, multiply,
//   accumulate and output registers. Results come from a single multiplier
//   that walks the four terms of each dot product in turn.
//   req_tready drops while both banks hold loaded pairs whose terms have not
//   all been issued to the multiplier.
//   A stalled rsp channel freezes the compute pipe; loading continues until
//   both banks are busy.
//   Reset clears the counters and the bank queue; the stores need no
//   clearing since every product reads only freshly loaded elements.
// ----------------------------------------------------------------------------
module matrix4x4_multiply (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] left_value, [63:32] right_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] product_value
   output logic [3:0]  rsp_tuser,   // [1:0] row_index, [3:2] column_index
   output logic        rsp_tlast
);
   import mm4_pkg::*;

   mm4_wr_type       wr;
   mm4_q_status_type q_status;
   logic             push;
   logic             push_bank;
   logic             pop;

   mm4_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .wr         (wr),
      .push       (push),
      .push_bank  (push_bank)
   );

   mm4_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_bank (push_bank),
      .pop       (pop),
      .q_status  (q_status)
   );

   mm4_back u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sim/tb_matrix4x4_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix4x4_multiply: self-checking bench for the 4x4 Q16.16 multiplier
// Streams matrix pairs into the req channel and predicts each sixteen-element
// product in a scoreboard: exact four-term dot products, arithmetic shift by
// the fraction width, saturation to 32 bits. A directed pair covers the
// saturation and truncation corners; random pairs follow, with random gaps
// on both channels, a stretch with no gaps, a long rsp stall that backs up
// the input, and drains between phases.
// ----------------------------------------------------------------------------

// one expected element of a product run
typedef struct {
   logic [31:0] value;
   logic [1:0]  row;
   logic [1:0]  col;
   logic        last;
} product_elem_type;

class product_scoreboard;
   localparam int DIM = mm4_pkg::MATRIX_DIM;
   localparam int AW  = mm4_pkg::ACC_W;

   logic signed [31:0] left_elems  [mm4_pkg::ELEMS];
   logic signed [31:0] right_elems [mm4_pkg::ELEMS];
   int unsigned        elems_loaded;
   product_elem_type   expected_products [$];
   int unsigned        mismatches;

   function new();
      elems_loaded = 0;
      mismatches   = 0;
   endfunction

   function int unsigned pending();
      return expected_products.size();
   endfunction

   // exact dot product, floor shift by the fraction width, clamp to 32 bits
   function logic [31:0] dot_value(int unsigned row, int unsigned col);
      logic signed [AW-1:0] acc;
      logic signed [63:0]   term;
      logic signed [AW-1:0] shifted;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         term = left_elems[row * DIM + k] * right_elems[k * DIM + col];
         acc  = acc + term;
      end
      shifted = acc >>> mm4_pkg::FRAC_BITS;
      if ((&shifted[AW-1:31]) || !(|shifted[AW-1:31])) begin
         return shifted[31:0];
      end
      return shifted[AW-1] ? mm4_pkg::SAT_MIN : mm4_pkg::SAT_MAX;
   endfunction

   // store one element pair; the pair that completes both matrices queues the product
   function void note_load(logic [31:0] left, logic [31:0] right);
      product_elem_type elem;
      if (elems_loaded >= mm4_pkg::ELEMS) begin
         elems_loaded = 0;
      end
      left_elems[elems_loaded]  = left;
      right_elems[elems_loaded] = right;
      elems_loaded++;
      if (elems_loaded < mm4_pkg::ELEMS) begin
         return;
      end
      elems_loaded = 0;
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            elem.value = dot_value(i, j);
            elem.row   = i[1:0];
            elem.col   = j[1:0];
            elem.last  = (i == DIM - 1) && (j == DIM - 1);
            expected_products.push_back(elem);
         end
      end
   endfunction

   // compare one received element with the oldest expected one
   function void check_product(logic [31:0] value, logic [1:0] row, logic [1:0] col,
                               logic last);
      product_elem_type exp_elem;
      if (expected_products.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: unexpected product element value=%h row=%0d col=%0d last=%b",
                     value, row, col, last);
         end
         return;
      end
      exp_elem = expected_products.pop_front();
      if (value !== exp_elem.value || row !== exp_elem.row || col !== exp_elem.col ||
          last !== exp_elem.last) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: product mismatch at %0t: expected value=%h row=%0d col=%0d last=%b",
                     $realtime, exp_elem.value, exp_elem.row, exp_elem.col, exp_elem.last);
            $display("                             actual   value=%h row=%0d col=%0d last=%b",
                     value, row, col, last);
         end
      end
   endfunction
endclass

module tb_matrix4x4_multiply;

   localparam int IDLE_PCT       = 28;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;    // [31:0] left_value, [63:32] right_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] product_value
   logic [3:0]  rsp_tuser;          // [1:0] row_index, [3:2] column_index
   logic        rsp_tlast;

   product_scoreboard sb = new();

   bit          sender_gaps     = 1'b1;
   bit          receiver_steady = 1'b0;
   int unsigned holds_asked     = 0;
   int unsigned stall_cycles    = 0;

   matrix4x4_multiply DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // observe both channels and watch for a stuck block
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_load(req_tdata[31:0], req_tdata[63:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_product(rsp_tdata, rsp_tuser[1:0], rsp_tuser[3:2], rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_matrix4x4_multiply: FAIL");
            $finish;
         end
      end
   end

   // rsp side: random back-pressure, a steady mode, and long hold-offs on request
   initial begin
      int unsigned holds_served;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_served) begin
            holds_served = holds_asked;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= receiver_steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // offer one transaction; called and returns just after a falling edge
   task automatic send_pair(input logic [31:0] left, input logic [31:0] right);
      while (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // pause the input until every queued product element has come back
   task automatic drain_products();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // mix of full-range, near-saturation, everyday and corner values
   function automatic logic [31:0] random_element();
      logic [31:0] v;
      logic [23:0] s24;
      logic [20:0] s21;
      logic [16:0] s17;
      s24 = 24'($urandom());
      s21 = 21'($urandom());
      s17 = 17'($urandom());
      case ($urandom_range(0, 9))
         0, 1:    v = $urandom();
         2: begin
            case ($urandom_range(0, 5))
               0:       v = mm4_pkg::SAT_MAX;
               1:       v = mm4_pkg::SAT_MIN;
               2:       v = 32'h0000_0000;
               3:       v = 32'hFFFF_FFFF;
               4:       v = 32'h0001_0000;
               default: v = 32'h0000_0001;
            endcase
         end
         3, 4:    v = {{8{s24[23]}}, s24};
         5, 6, 7: v = {{11{s21[20]}}, s21};
         default: v = {{15{s17[16]}}, s17};
      endcase
      return v;
   endfunction

   task automatic send_random_products(input int unsigned count);
      repeat (count * mm4_pkg::ELEMS) begin
         send_pair(random_element(), random_element());
      end
   endtask

   // directed pair: positive and negative saturation, floor of a tiny negative
   // sum, and a sum one step past the positive limit
   task automatic send_corner_product();
      logic [31:0] left;
      logic [31:0] right;
      int          r;
      int          c;
      for (int idx = 0; idx < mm4_pkg::ELEMS; idx++) begin
         r = idx / mm4_pkg::MATRIX_DIM;
         c = idx % mm4_pkg::MATRIX_DIM;
         case (r)
            0:       left = mm4_pkg::SAT_MAX;
            1:       left = mm4_pkg::SAT_MIN;
            2:       left = 32'hFFFF_FFFF;
            default: left = (c < 2) ? 32'h0001_0000 : 32'h0000_0000;
         endcase
         case (c)
            0:       right = mm4_pkg::SAT_MAX;
            1:       right = mm4_pkg::SAT_MIN;
            2:       right = 32'h0000_0001;
            default: right = (r == 0) ? mm4_pkg::SAT_MAX :
                             (r == 1) ? 32'h0000_0001 : 32'h0000_0000;
         endcase
         send_pair(left, right);
      end
   endtask

   // main sequence
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_corner_product();
      drain_products();

      // random gaps on both sides
      send_random_products(10);

      // stretch with no idling
      sender_gaps     = 1'b0;
      receiver_steady = 1'b1;
      send_random_products(6);

      // hold the rsp side off while the input keeps pushing
      receiver_steady = 1'b0;
      holds_asked++;
      send_random_products(4);
      sender_gaps = 1'b1;
      drain_products();

      send_random_products(9);
      drain_products();

      if (sb.mismatches == 0) begin
         $display("tb_matrix4x4_multiply: PASS");
      end else begin
         $display("tb_matrix4x4_multiply: FAIL");
      end
      $finish;
   end

endmodule
